FILE: sv/rbnh_pkg.sv
// ----------------------------------------------------------------------------
// rbnh_pkg: shared types for the ray / box nearest-hit block
// Holds the per-axis edge record passed from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none
package rbnh_pkg;

  // One box, classified by the front end: edges relative to the ray origin.
  typedef struct packed {
    logic signed [33:0] lo_x;   // box low edge minus origin, x
    logic signed [33:0] hi_x;
    logic signed [33:0] lo_y;
    logic signed [33:0] hi_y;
    logic signed [32:0] d_x;    // ray extent, x
    logic signed [32:0] d_y;
    logic signed [31:0] o_x;    // ray origin
    logic signed [31:0] o_y;
    logic signed [31:0] c_x;    // box center
    logic signed [31:0] c_y;
    logic        [30:0] hw;
    logic        [30:0] hh;
    logic        [31:0] id;
    logic               last;
  } box_job_t;

endpackage
`default_nettype wire

FILE: sv/rbnh_divider.sv
// ----------------------------------------------------------------------------
// rbnh_divider: iterative floor divider
// Restoring division, one quotient bit per cycle, sign fixed to floor.
// ----------------------------------------------------------------------------
`default_nettype none
module rbnh_divider #(
  parameter int NW = 58,
  parameter int DW = 33
) (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  start,
  input  wire signed [NW-1:0]  num,
  input  wire signed [DW-1:0]  den,
  output logic                 done,
  output logic signed [NW:0]   quo
);
  localparam int CW = $clog2(NW + 1);
  logic [NW-1:0] qreg;
  logic [NW:0]   rem;
  logic [DW-1:0] dmag;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          neg;
  logic [NW:0]   trial;
  logic [NW-1:0] nmag;

  assign nmag  = num[NW-1] ? NW'(-num) : NW'(num);
  assign trial = {rem[NW-1:0], qreg[NW-1]};

  always_ff @(posedge clk) begin
    done <= !rst && !start && busy && (cnt == CW'(1));
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
      qreg <= nmag;
      rem  <= '0;
      dmag <= den[DW-1] ? DW'(-den) : DW'(den);
      neg  <= num[NW-1] ^ den[DW-1];
    end else if (busy) begin
      if (trial >= (NW+1)'(dmag)) begin
        rem  <= trial - (NW+1)'(dmag);
        qreg <= {qreg[NW-2:0], 1'b1};
      end else begin
        rem  <= trial;
        qreg <= {qreg[NW-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  // rem/qreg hold final values once done pulses
  always_comb begin
    if (neg) quo = (rem != '0) ? -$signed({1'b0, qreg}) - 1 : -$signed({1'b0, qreg});
    else     quo = $signed({1'b0, qreg});
  end
endmodule
`default_nettype wire

FILE: sv/rbnh_front.sv
// ----------------------------------------------------------------------------
// rbnh_front: box intake
// Forms edges relative to the origin and a two-entry queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module rbnh_front
  import rbnh_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_ready,
  input  wire signed [31:0] ox, oy, ex, ey,
  input  wire signed [31:0] cx, cy,
  input  wire [30:0]       hw, hh,
  input  wire [31:0]       id,
  input  wire              last,
  output logic             q_valid,
  input  wire              q_pop,
  output box_job_t         q_job
);
  box_job_t      mem [2];
  logic          wp, rp;
  logic [1:0]    cnt;
  box_job_t      j;

  always_comb begin
    j.lo_x = 34'(cx) - 34'(hw) - 34'(ox);
    j.hi_x = 34'(cx) + 34'(hw) - 34'(ox);
    j.lo_y = 34'(cy) - 34'(hh) - 34'(oy);
    j.hi_y = 34'(cy) + 34'(hh) - 34'(oy);
    j.d_x  = 33'(ex) - 33'(ox);
    j.d_y  = 33'(ey) - 33'(oy);
    j.o_x = ox; j.o_y = oy; j.c_x = cx; j.c_y = cy;
    j.hw = hw; j.hh = hh; j.id = id; j.last = last;
  end

  assign in_ready = (cnt != 2'd2);
  assign q_valid  = (cnt != 2'd0);
  assign q_job    = mem[rp];

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) mem[wp] <= j;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (in_valid && in_ready) wp <= ~wp;
      if (q_pop) rp <= ~rp;
      cnt <= cnt + 2'(in_valid && in_ready) - 2'(q_pop);
    end
  end

  a_pop_ok: assert property (@(posedge clk) disable iff (rst) q_pop |-> cnt != 2'd0)
    else $error("pop of empty queue");
endmodule
`default_nettype wire

FILE: sv/rbnh_back.sv
// ----------------------------------------------------------------------------
// rbnh_back: slab clipping, hit point, side and keep-best
// Sequencer shares one divider across the four slab fractions of a box.
// ----------------------------------------------------------------------------
`default_nettype none
module rbnh_back
  import rbnh_pkg::*;
#(
  parameter int FB = 16,
  parameter int IB = 16
) (
  input  wire            clk,
  input  wire            rst,
  input  wire            q_valid,
  output logic           q_pop,
  input  box_job_t       job_in,
  output logic           out_valid,
  input  wire            out_ready,
  output logic           hit,
  output logic [IB-1:0]  hit_id,
  output logic [FB:0]    hit_fraction,
  output logic signed [31:0] hit_x,
  output logic signed [31:0] hit_y,
  output logic [1:0]     hit_side
);
  localparam int NW = 34 + FB;
  localparam int FW = FB + 3;
  localparam logic signed [FW-1:0] ONE = FW'(1) <<< FB;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001, S_DIV = 8'b00000010, S_WAIT = 8'b00000100,
    S_CLIP = 8'b00001000, S_MUL = 8'b00010000, S_SIDE = 8'b00100000,
    S_KEEP = 8'b01000000, S_OUT = 8'b10000000
  } st_t;
  st_t st;

  box_job_t job;
  logic [1:0] step;         // 0 lo_x, 1 hi_x, 2 lo_y, 3 hi_y
  logic signed [FW-1:0] fa, flo, fhi, fbest;
  logic alive;
  logic dstart, ddone;
  logic signed [NW-1:0] dnum;
  logic signed [32:0]   dden;
  logic signed [NW:0]   dq;
  logic signed [FW-1:0] fsat;
  logic signed [33:0] edge_v;
  logic signed [32:0] dax;
  logic signed [31:0] px, py;
  logic [63:0] sl, sr;
  logic found;
  logic [IB-1:0] bid;
  logic signed [31:0] bx, by;
  logic [1:0] bside;

  assign dax    = step[1] ? job.d_y : job.d_x;
  always_comb begin
    unique case (step)
      2'd0:    edge_v = job.lo_x;
      2'd1:    edge_v = job.hi_x;
      2'd2:    edge_v = job.lo_y;
      default: edge_v = job.hi_y;
    endcase
  end
  assign dnum = NW'(edge_v) <<< FB;
  assign dden = dax;

  rbnh_divider #(.NW(NW), .DW(33)) u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(dden),
    .done(ddone), .quo(dq)
  );

  always_comb begin
    if (dq < -1)                 fsat = -FW'(1);
    else if (dq > (NW+1)'(ONE) + 1) fsat = ONE + FW'(1);
    else                         fsat = FW'(dq);
  end

  // hit point: origin + floor(d * flo / ONE); flo in 0..ONE
  logic signed [33+FB:0] mx, my;
  logic signed [33:0] dxp, dyp;
  logic [32:0] adx, ady;
  assign dxp = 34'(px) - 34'(job.c_x);
  assign dyp = 34'(py) - 34'(job.c_y);
  assign adx = dxp[33] ? 33'(-dxp) : 33'(dxp);
  assign ady = dyp[33] ? 33'(-dyp) : 33'(dyp);
  assign sl  = 64'(adx) * 64'(job.hh);
  assign sr  = 64'(ady) * 64'(job.hw);

  assign dstart = (st == S_DIV);
  assign q_pop  = (st == S_IDLE) && q_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; out_valid <= 1'b0; found <= 1'b0;
      fbest <= ONE; bid <= '0; bx <= '0; by <= '0; bside <= '0;
    end else begin
      unique case (st)
        S_IDLE: if (q_valid) begin
          job <= job_in; step <= 2'd0; alive <= 1'b1;
          flo <= '0; fhi <= ONE;
          st <= S_CLIP;
        end
        S_CLIP: begin
          // zero extent: overlap test, window unchanged
          if (dax == '0) begin
            if (!((step[1] ? job.lo_y : job.lo_x) <= 0 &&
                  (step[1] ? job.hi_y : job.hi_x) >= 0))
              alive <= 1'b0;
            step <= (step[1] || !alive) ? 2'd0 : step + 2'd2;
            st   <= (step[1] || !alive) ? S_MUL : S_CLIP;
          end else if (!alive) begin
            st <= S_MUL;
          end else begin
            st <= S_DIV;
          end
        end
        S_DIV: st <= S_WAIT;
        S_WAIT: if (ddone) begin
          if (!step[0]) begin
            fa <= fsat; step <= step + 2'd1; st <= S_DIV;
          end else begin
            logic signed [FW-1:0] a, b;
            a = (fa > fsat) ? fsat : fa;
            b = (fa > fsat) ? fa : fsat;
            if (b < flo || a > fhi) alive <= 1'b0;
            else begin
              if (a > flo) flo <= a;
              if (b < fhi) fhi <= b;
              if ((a > flo ? a : flo) > (b < fhi ? b : fhi)) alive <= 1'b0;
            end
            if (step[1]) begin step <= 2'd0; st <= S_MUL; end
            else begin step <= 2'd2; st <= S_CLIP; end
          end
        end
        S_MUL: begin
          mx <= (34+FB)'(job.d_x) * (34+FB)'(flo);
          my <= (34+FB)'(job.d_y) * (34+FB)'(flo);
          if (alive && flo < fbest) begin
            st <= S_SIDE;
          end else if (job.last) begin
            // no new best on the last box: report what is kept
            st <= S_OUT;
            out_valid <= 1'b1;
            hit <= found; hit_id <= found ? bid : '0;
            hit_fraction <= found ? (FB+1)'(fbest) : '0;
            hit_x <= found ? bx : '0; hit_y <= found ? by : '0;
            hit_side <= found ? bside : '0;
          end else begin
            st <= S_IDLE;
          end
        end
        S_SIDE: begin
          px <= job.o_x + 32'(mx >>> FB);
          py <= job.o_y + 32'(my >>> FB);
          st <= S_KEEP;
        end
        S_KEEP: begin
          fbest <= flo; bid <= IB'(job.id); bx <= px; by <= py; found <= 1'b1;
          if (sl > sr) bside <= dxp[33] ? 2'd0 : 2'd1;
          else         bside <= dyp[33] ? 2'd2 : 2'd3;
          if (job.last) begin
            out_valid <= 1'b1; hit <= 1'b1; hit_id <= IB'(job.id);
            hit_fraction <= (FB+1)'(flo); hit_x <= px; hit_y <= py;
            hit_side <= (sl > sr) ? (dxp[33] ? 2'd0 : 2'd1)
                                  : (dyp[33] ? 2'd2 : 2'd3);
            st <= S_OUT;
          end else st <= S_IDLE;
        end
        S_OUT: begin
          found <= 1'b0; fbest <= ONE; bid <= '0; bx <= '0; by <= '0; bside <= '0;
          if (out_ready) begin out_valid <= 1'b0; st <= S_IDLE; end
        end
        default: st <= S_IDLE;
      endcase
    end
  end

  a_out_state: assert property (@(posedge clk) disable iff (rst)
    (st == S_OUT) |-> out_valid) else $error("result not shown");
  a_best_range: assert property (@(posedge clk) disable iff (rst)
    fbest >= 0 && fbest <= ONE) else $error("best fraction out of range");
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    q_pop |=> st == S_CLIP) else $error("pop outside idle");
endmodule
`default_nettype wire

FILE: sv/ray_box_nearest_hit.sv
// ----------------------------------------------------------------------------
// ray_box_nearest_hit: nearest hit of a 2D ray segment against a box stream
// Slab clipping per box; keeps the nearest entry fraction, reports on last box.
// ----------------------------------------------------------------------------
//  channel  | handshake            | payload
//  cfg      | cfg_valid/cfg_ready  | cfg_index, cfg_data (ray origin / end)
//  in       | in_valid/in_ready    | one box per transaction
//  out      | out_valid/out_ready  | one result per scene, on last box
//
//  A box runs up to four floor divisions through the one shared bit-serial
//  divider, then multiply, side and keep steps.
//  The front queue holds two boxes, so intake runs ahead of the back end.
//  Reset is synchronous; it clears the search state and the registers.
//  A waiting result holds the back end until taken.
// ----------------------------------------------------------------------------
`default_nettype none
module ray_box_nearest_hit
  import rbnh_pkg::*;
#(
  parameter int FRAC_BITS = 16,
  parameter int ID_BITS   = 16
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire [1:0]             cfg_index,
  input  wire [31:0]            cfg_data,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire signed [31:0]     center_x,
  input  wire signed [31:0]     center_y,
  input  wire [30:0]            half_width,
  input  wire [30:0]            half_height,
  input  wire [ID_BITS-1:0]     box_id,
  input  wire                   last_box,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic                  hit,
  output logic [ID_BITS-1:0]    hit_id,
  output logic [FRAC_BITS:0]    hit_fraction,
  output logic signed [31:0]    hit_x,
  output logic signed [31:0]    hit_y,
  output logic [1:0]            hit_side
);
  logic signed [31:0] ray_origin_x, ray_origin_y, ray_end_x, ray_end_y;
  logic     q_valid, q_pop;
  box_job_t q_job;

  assign cfg_ready = 1'b1;

  // Hold the ray registers; a write lands on the next edge.
  always_ff @(posedge clk) begin
    if (rst) begin
      ray_origin_x <= '0; ray_origin_y <= '0; ray_end_x <= '0; ray_end_y <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        2'd0:    ray_origin_x <= cfg_data;
        2'd1:    ray_origin_y <= cfg_data;
        2'd2:    ray_end_x    <= cfg_data;
        default: ray_end_y    <= cfg_data;
      endcase
    end
  end

  rbnh_front u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .ox(ray_origin_x), .oy(ray_origin_y), .ex(ray_end_x), .ey(ray_end_y),
    .cx(center_x), .cy(center_y), .hw(half_width), .hh(half_height),
    .id(32'(box_id)), .last(last_box),
    .q_valid(q_valid), .q_pop(q_pop), .q_job(q_job)
  );

  rbnh_back #(.FB(FRAC_BITS), .IB(ID_BITS)) u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_pop(q_pop), .job_in(q_job),
    .out_valid(out_valid), .out_ready(out_ready), .hit(hit), .hit_id(hit_id),
    .hit_fraction(hit_fraction), .hit_x(hit_x), .hit_y(hit_y),
    .hit_side(hit_side)
  );
endmodule
`default_nettype wire
